/* rtl/mmss_pkg.sv */
// Package for the Markov model step sampler: constants, mode codes, controller/datapath structs.
// No dependencies.
`default_nettype none
package mmss_pkg;
  localparam int MAX_STATES_D  = 1024;
  localparam int MAX_ROWS_D    = 4096;
  localparam int MAX_ENTRIES_D = 16384;
  localparam int NUM_RM_D      = 4;
  localparam int PROB_FB_D     = 16;

  localparam int MODE_W = 3;
  localparam int ADDR_W = 15;
  localparam int COL_W  = 10;
  localparam int WORD_W = 15;
  localparam int PROB_W = 17;
  localparam int REW_W  = 32;
  localparam int RM_W   = 2;
  localparam int ACT_W  = 12;
  localparam int FRAC_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_GROUP  = 3'd0,
    MODE_ROW    = 3'd1,
    MODE_ENTRY  = 3'd2,
    MODE_SREW   = 3'd3,
    MODE_AREW   = 3'd4,
    MODE_STEP   = 3'd5,
    MODE_RSTEP  = 3'd6,
    MODE_RESET  = 3'd7
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUSED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMASK = 2'd3;

  // Datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RD_G0, OP_RD_G1, OP_CHK_GRP, OP_RD_ROW,
    OP_RD_AREW, OP_ACC_AREW, OP_RD_E, OP_SUM_E, OP_RD_SREW, OP_ACC_SREW,
    OP_INIT, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] m;      // reward model in focus
    logic       mul;    // random step action multiply
  } cmd_t;

  typedef struct packed {
    logic grp_bad;   // empty group or action out of range
    logic row_done;  // entry walk exhausted
    logic hit;       // running sum exceeded the fraction
    logic col_bad;   // hit column out of range
    logic load_ok;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/mmss_if.sv */
// Valid/ready stream interfaces for the sampler's input and result channels.
// Depends on mmss_pkg.
`default_nettype none
interface mmss_in_if;
  import mmss_pkg::*;
  logic valid, ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] table_address;
  logic [COL_W-1:0]  target_column;
  logic [WORD_W-1:0] load_word;
  logic [PROB_W-1:0] entry_probability;
  logic signed [REW_W-1:0] reward_value;
  logic [RM_W-1:0]   reward_model;
  logic [ACT_W-1:0]  action_index;
  logic [FRAC_W-1:0] random_fraction;
  logic [FRAC_W-1:0] action_fraction;
  modport source(output valid, mode, table_address, target_column, load_word,
    entry_probability, reward_value, reward_model, action_index, random_fraction,
    action_fraction, input ready);
  modport sink(input valid, mode, table_address, target_column, load_word,
    entry_probability, reward_value, reward_model, action_index, random_fraction,
    action_fraction, output ready);
endinterface

interface mmss_out_if;
  import mmss_pkg::*;
  logic valid, ready;
  logic success;
  logic [COL_W-1:0] current_state;
  logic [RM_W-1:0] reward_model_index;
  logic signed [REW_W-1:0] last_reward;
  logic last_of_run;
  modport source(output valid, success, current_state, reward_model_index,
    last_reward, last_of_run, input ready);
  modport sink(input valid, success, current_state, reward_model_index,
    last_reward, last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/markov_model_step_sampler.sv */
// Top level of the Markov model step sampler: config registers, item latch, ctrl + datapath.
// Depends on mmss_pkg, mmss_if, mmss_ctrl, mmss_datapath.
//
// Usage: load items (modes 0..4) write the model tables and return one transaction with
// its success flag. Step items (5, 6) walk the current state's chosen row entry by entry
// and return one result transaction per reported reward model, last_of_run on the final.
// Reset items (7) enter initial_state and report its state rewards.
// A failed step stops early and skips the state reward pass. One item is in work at a
// time: in.ready is high only while idle; a step takes longer the more entries it walks.
// Results sit in a held output register; a stalled receiver freezes the block until taken.
// Reset (rst_n low, synchronous) clears the present state, accumulators and config
// registers; the model tables hold no reset value and must be loaded before use.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle: the user must
// keep to this, as the block itself does not enforce it.
`default_nettype none
module markov_model_step_sampler #(
  parameter int MAX_STATES  = mmss_pkg::MAX_STATES_D,
  parameter int MAX_ROWS    = mmss_pkg::MAX_ROWS_D,
  parameter int MAX_ENTRIES = mmss_pkg::MAX_ENTRIES_D,
  parameter int NUM_RM      = mmss_pkg::NUM_RM_D,
  parameter int PROB_FB     = mmss_pkg::PROB_FB_D
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mmss_in_if.sink   in_ch,
  mmss_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [mmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mmss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mmss_pkg::*;
  logic [COL_W-1:0] init_r;
  logic [2:0] nused_r;
  logic [3:0] smask_r, amask_r;
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] addr_r;
  logic [COL_W-1:0] col_r;
  logic [WORD_W-1:0] word_r;
  logic [PROB_W-1:0] prob_r;
  logic [REW_W-1:0] rew_r;
  logic [RM_W-1:0] model_r;
  logic [ACT_W-1:0] act_r;
  logic [FRAC_W-1:0] u_r, af_r;
  logic busy, in_fire, ozero;
  logic [1:0] rd_m;
  cmd_t cmd;
  sts_t sts;
  logic signed [REW_W-1:0] acc;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0; nused_r <= '0; smask_r <= '0; amask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT:  init_r <= cfg_data;
        CFG_NUSED: nused_r <= cfg_data[2:0];
        CFG_SMASK: smask_r <= cfg_data[3:0];
        CFG_AMASK: amask_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // item latch; load decode uses the live payload in the accept cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode; addr_r <= in_ch.table_address; col_r <= in_ch.target_column;
      word_r <= in_ch.load_word; prob_r <= in_ch.entry_probability;
      rew_r <= in_ch.reward_value; model_r <= in_ch.reward_model;
      act_r <= in_ch.action_index; u_r <= in_ch.random_fraction;
      af_r <= in_ch.action_fraction;
    end
  end

  logic [MODE_W-1:0] mode_s;
  logic [FRAC_W-1:0] af_s;
  logic [ACT_W-1:0] act_s;
  assign mode_s = busy ? mode_r : in_ch.mode;
  assign af_s = busy ? af_r : in_ch.action_fraction;
  assign act_s = busy ? act_r : in_ch.action_index;

  mmss_ctrl #(.NUM_RM(NUM_RM)) u_ctrl (
    .clk, .rst_n, .in_fire, .mode(mode_s), .nused(nused_r), .sts, .cmd, .busy, .rd_m,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_success(out_ch.success),
    .out_index(out_ch.reward_model_index), .out_zero(ozero), .out_last(out_ch.last_of_run));

  mmss_datapath #(.MAX_STATES(MAX_STATES), .MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES),
    .NUM_RM(NUM_RM), .PROB_FB(PROB_FB)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mode(mode_s), .addr(busy ? addr_r : in_ch.table_address),
    .col(busy ? col_r : in_ch.target_column), .word(busy ? word_r : in_ch.load_word),
    .prob(busy ? prob_r : in_ch.entry_probability),
    .rew(busy ? rew_r : in_ch.reward_value), .model(busy ? model_r : in_ch.reward_model),
    .act(act_s), .u(u_r), .af(af_s), .init_state(init_r), .nused(nused_r),
    .smask(smask_r), .amask(amask_r),
    .rd_m, .state_q(out_ch.current_state), .acc_q(acc));

  assign out_ch.last_reward = ozero ? '0 : acc;
endmodule
`default_nettype wire

/* rtl/mmss_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/mmss_datapath.sv */
// Sampler datapath: model tables, state register, reward accumulators, walk arithmetic.
// Depends on mmss_pkg and mmss_ram.
`default_nettype none
module mmss_datapath #(
  parameter int MAX_STATES  = mmss_pkg::MAX_STATES_D,
  parameter int MAX_ROWS    = mmss_pkg::MAX_ROWS_D,
  parameter int MAX_ENTRIES = mmss_pkg::MAX_ENTRIES_D,
  parameter int NUM_RM      = mmss_pkg::NUM_RM_D,
  parameter int PROB_FB     = mmss_pkg::PROB_FB_D
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mmss_pkg::cmd_t cmd,
  output mmss_pkg::sts_t sts,
  // latched item
  input  wire logic [mmss_pkg::MODE_W-1:0] mode,
  input  wire logic [mmss_pkg::ADDR_W-1:0] addr,
  input  wire logic [mmss_pkg::COL_W-1:0]  col,
  input  wire logic [mmss_pkg::WORD_W-1:0] word,
  input  wire logic [mmss_pkg::PROB_W-1:0] prob,
  input  wire logic [mmss_pkg::REW_W-1:0]  rew,
  input  wire logic [mmss_pkg::RM_W-1:0]   model,
  input  wire logic [mmss_pkg::ACT_W-1:0]  act,
  input  wire logic [mmss_pkg::FRAC_W-1:0] u,
  input  wire logic [mmss_pkg::FRAC_W-1:0] af,
  input  wire logic [mmss_pkg::COL_W-1:0]  init_state,
  input  wire logic [2:0] nused,
  input  wire logic [3:0] smask,
  input  wire logic [3:0] amask,
  input  wire logic [1:0] rd_m,
  output logic [mmss_pkg::COL_W-1:0] state_q,
  output logic signed [mmss_pkg::REW_W-1:0] acc_q
);
  import mmss_pkg::*;
  localparam int SW  = $clog2(MAX_STATES + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int SAW = $clog2(MAX_STATES);
  localparam int RAW = $clog2(MAX_ROWS);
  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int MW  = (NUM_RM > 1) ? $clog2(NUM_RM) : 1;
  localparam int SUMW = PROB_W + EW;

  logic [SW-1:0] g_addr;
  logic [RW-1:0] r_addr;
  logic [EAW-1:0] e_addr;
  logic [MW+SAW-1:0] sr_addr;
  logic [MW+RAW-1:0] ar_addr;
  logic [WORD_W-1:0] g_rd, r_rd;
  logic [COL_W-1:0] c_rd;
  logic [PROB_W-1:0] p_rd;
  logic [REW_W-1:0] sr_rd, ar_rd;

  logic [RW-1:0] g0_r, g1_r, row_r;
  logic [EW-1:0] e_r, e1_r;
  logic [SUMW-1:0] sum_r;
  logic [COL_W-1:0] cur_r, nst_r;
  logic signed [REW_W-1:0] acc_r [4];
  logic [RW-1:0] gsize;
  logic [RW+FRAC_W-1:0] prod;
  logic [RW-1:0] action;

  // load decode
  logic wg, wr, we_, ws, wa;
  logic [MODE_W-1:0] md;
  always_comb begin
    md = mode;
    wg = 1'b0; wr = 1'b0; we_ = 1'b0; ws = 1'b0; wa = 1'b0;
    case (mode_t'(md))
      MODE_GROUP: wg = 32'(addr) <= MAX_STATES;
      MODE_ROW:   wr = 32'(addr) <= MAX_ROWS;
      MODE_ENTRY: we_ = 32'(addr) < MAX_ENTRIES;
      MODE_SREW:  ws = 32'(addr) < MAX_STATES && 32'(model) < NUM_RM;
      MODE_AREW:  wa = 32'(addr) < MAX_ROWS && 32'(model) < NUM_RM;
      default: ;
    endcase
  end
  logic ld;
  assign ld = cmd.op == OP_LOAD;
  assign sts.load_ok = wg | wr | we_ | ws | wa;

  // read address selection; the row start read goes out while row_r is loaded
  always_comb begin
    g_addr = (cmd.op == OP_RD_G1) ? SW'(cur_r) + SW'(1) : SW'(cur_r);
    r_addr = (cmd.op == OP_RD_ROW) ? g0_r + action : row_r + RW'(1);
    e_addr = EAW'(e_r);
    sr_addr = {MW'(rd_m), SAW'(nst_r)};
    ar_addr = {MW'(rd_m), RAW'(row_r)};
    if (ld) begin
      g_addr = SW'(addr); r_addr = RW'(addr); e_addr = EAW'(addr);
      sr_addr = {MW'(model), SAW'(addr)}; ar_addr = {MW'(model), RAW'(addr)};
    end
  end

  mmss_ram #(.WIDTH(WORD_W), .DEPTH(MAX_STATES+1), .AW(SW)) u_grp (.clk, .we(ld & wg),
    .waddr(g_addr), .wdata(word), .raddr(g_addr), .rdata(g_rd));
  mmss_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS+1), .AW(RW)) u_row (.clk, .we(ld & wr),
    .waddr(r_addr), .wdata(word), .raddr(r_addr), .rdata(r_rd));
  mmss_ram #(.WIDTH(COL_W), .DEPTH(MAX_ENTRIES), .AW(EAW)) u_col (.clk, .we(ld & we_),
    .waddr(e_addr), .wdata(col), .raddr(e_addr), .rdata(c_rd));
  mmss_ram #(.WIDTH(PROB_W), .DEPTH(MAX_ENTRIES), .AW(EAW)) u_prb (.clk, .we(ld & we_),
    .waddr(e_addr), .wdata(prob), .raddr(e_addr), .rdata(p_rd));
  mmss_ram #(.WIDTH(REW_W), .DEPTH(NUM_RM*MAX_STATES), .AW(MW+SAW)) u_srw (.clk,
    .we(ld & ws), .waddr(sr_addr), .wdata(rew), .raddr(sr_addr), .rdata(sr_rd));
  mmss_ram #(.WIDTH(REW_W), .DEPTH(NUM_RM*MAX_ROWS), .AW(MW+RAW)) u_arw (.clk,
    .we(ld & wa), .waddr(ar_addr), .wdata(rew), .raddr(ar_addr), .rdata(ar_rd));

  // saturating add of table reward into accumulator
  function automatic logic signed [REW_W-1:0] sat(input logic signed [REW_W-1:0] a,
                                                  input logic [REW_W-1:0] b);
    logic signed [REW_W:0] s;
    s = {a[REW_W-1], a} + {b[REW_W-1], b};
    if (s[REW_W] != s[REW_W-1]) sat = s[REW_W] ? {1'b1, {(REW_W-1){1'b0}}}
                                               : {1'b0, {(REW_W-1){1'b1}}};
    else sat = s[REW_W-1:0];
  endfunction

  assign gsize = g1_r - g0_r;
  assign prod = (RW+FRAC_W)'(af) * (RW+FRAC_W)'(gsize);
  assign action = cmd.mul ? RW'(prod >> PROB_FB) : RW'(act);

  logic [SUMW-1:0] sum_n;
  assign sum_n = sum_r + SUMW'(p_rd);
  assign sts.grp_bad = (g1_r <= g0_r) || (cmd.mul ? 1'b0 : (32'(act) >= 32'(gsize)))
                       || (32'(action) >= 32'(gsize));
  assign sts.row_done = e_r >= e1_r;
  assign sts.hit = sum_n > SUMW'(u);
  assign sts.col_bad = 32'(c_rd) >= MAX_STATES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else begin
      case (cmd.op)
        // a group start past the row table leaves the group empty either way
        OP_RD_G1: g0_r <= (32'(g_rd) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(g_rd);
        OP_CHK_GRP: begin
          g1_r <= (32'(g_rd) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(g_rd);
        end
        OP_RD_ROW: row_r <= g0_r + action;
        OP_RD_AREW: begin
          for (int i = 0; i < 4; i++) acc_r[i] <= '0;
          e_r <= EW'(r_rd);
        end
        OP_ACC_AREW: begin
          if (cmd.m == 2'd0) e1_r <= (32'(r_rd) > MAX_ENTRIES) ? EW'(MAX_ENTRIES) : EW'(r_rd);
          if (amask[cmd.m] && 32'(cmd.m) < NUM_RM && {1'b0, cmd.m} < nused)
            acc_r[cmd.m] <= sat(acc_r[cmd.m], ar_rd);
          sum_r <= '0;
        end
        OP_SUM_E: begin
          sum_r <= sum_n; e_r <= e_r + EW'(1); nst_r <= c_rd;
        end
        OP_INIT: begin
          nst_r <= (32'(init_state) >= MAX_STATES) ? COL_W'(MAX_STATES-1) : init_state;
          for (int i = 0; i < 4; i++) acc_r[i] <= '0;
        end
        OP_ACC_SREW:
          if (smask[cmd.m] && 32'(cmd.m) < NUM_RM && {1'b0, cmd.m} < nused)
            acc_r[cmd.m] <= sat(acc_r[cmd.m], sr_rd);
        OP_COMMIT: cur_r <= nst_r;
        default: ;
      endcase
    end
  end

  assign state_q = cur_r;
  assign acc_q = acc_r[rd_m];
endmodule
`default_nettype wire

/* rtl/mmss_ctrl.sv */
// Sampler controller: sequences loads, steps, resets and result emission.
// Depends on mmss_pkg.
`default_nettype none
module mmss_ctrl #(
  parameter int NUM_RM = mmss_pkg::NUM_RM_D
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic [mmss_pkg::MODE_W-1:0] mode,
  input  wire logic [2:0] nused,
  input  wire mmss_pkg::sts_t sts,
  output mmss_pkg::cmd_t cmd,
  output logic busy,
  output logic [1:0] rd_m,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_success,
  output logic [1:0] out_index,
  output logic out_zero,
  output logic out_last
);
  import mmss_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_G0, S_G1, S_GCHK, S_ROW, S_AREW, S_AACC, S_EREQ, S_ESUM,
    S_SREQ, S_SACC, S_COMMIT, S_EMIT
  } st_t;
  st_t st_r, st_nxt;
  logic [1:0] m_r, m_nxt;
  logic ok_r, ok_nxt, ov_r, ov_nxt, ld_r, ld_nxt;
  logic [2:0] n;
  cmd_t c;

  assign n = (32'(nused) > NUM_RM) ? 3'(NUM_RM) : ((nused > 3'd4) ? 3'd4 : nused);

  always_comb begin
    st_nxt = st_r; m_nxt = m_r; ok_nxt = ok_r; ov_nxt = ov_r; ld_nxt = ld_r;
    c = '{op: OP_NONE, m: m_r, mul: (mode == MODE_RSTEP)};
    case (st_r)
      S_IDLE: if (in_fire) begin
        if (mode == MODE_RESET) begin
          c.op = OP_INIT; m_nxt = '0; ok_nxt = 1'b1; ld_nxt = 1'b0; st_nxt = S_SREQ;
        end else if (mode == MODE_STEP || mode == MODE_RSTEP) begin
          c.op = OP_RD_G0; ld_nxt = 1'b0; st_nxt = S_G0;
        end else begin
          c.op = OP_LOAD; ok_nxt = sts.load_ok; ld_nxt = 1'b1; m_nxt = '0;
          ov_nxt = 1'b1; st_nxt = S_EMIT;
        end
      end
      S_G0: begin c.op = OP_RD_G1; st_nxt = S_G1; end
      S_G1: begin c.op = OP_CHK_GRP; st_nxt = S_GCHK; end
      S_GCHK: if (sts.grp_bad) begin
        ok_nxt = 1'b0; m_nxt = '0; ov_nxt = 1'b1; st_nxt = S_EMIT;
      end else begin
        c.op = OP_RD_ROW; st_nxt = S_ROW;
      end
      S_ROW: begin c.op = OP_RD_AREW; m_nxt = '0; st_nxt = S_AREW; end
      S_AREW: begin c.op = OP_NONE; st_nxt = S_AACC; end
      S_AACC: begin
        c.op = OP_ACC_AREW;
        if (m_r == 2'd3) begin m_nxt = '0; st_nxt = S_EREQ; end
        else begin m_nxt = m_r + 2'd1; st_nxt = S_AREW; end
      end
      S_EREQ: if (sts.row_done) begin
        ok_nxt = 1'b0; m_nxt = '0; ov_nxt = 1'b1; st_nxt = S_EMIT;
      end else st_nxt = S_ESUM;
      S_ESUM: if (sts.hit) begin
        c.op = OP_SUM_E;
        if (sts.col_bad) begin ok_nxt = 1'b0; m_nxt = '0; ov_nxt = 1'b1; st_nxt = S_EMIT; end
        else begin ok_nxt = 1'b1; m_nxt = '0; st_nxt = S_SREQ; end
      end else begin
        c.op = OP_SUM_E; st_nxt = S_EREQ;
      end
      S_SREQ: st_nxt = S_SACC;
      S_SACC: begin
        c.op = OP_ACC_SREW;
        if (m_r == 2'd3) begin m_nxt = '0; st_nxt = S_COMMIT; end
        else begin m_nxt = m_r + 2'd1; st_nxt = S_SREQ; end
      end
      S_COMMIT: begin c.op = OP_COMMIT; ov_nxt = 1'b1; st_nxt = S_EMIT; end
      S_EMIT: if (out_ready) begin
        if (ld_r || n == 3'd0 || 3'(m_r) + 3'd1 >= n) begin ov_nxt = 1'b0; st_nxt = S_IDLE; end
        else m_nxt = m_r + 2'd1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; m_r <= '0; ok_r <= 1'b0; ov_r <= 1'b0; ld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; m_r <= m_nxt; ok_r <= ok_nxt; ov_r <= ov_nxt; ld_r <= ld_nxt;
    end
  end

  assign cmd = c;
  assign busy = st_r != S_IDLE;
  assign rd_m = m_r;
  assign out_valid = ov_r;
  assign out_success = ok_r;
  assign out_index = (ld_r || n == 3'd0) ? 2'd0 : m_r;
  assign out_zero = ld_r || n == 3'd0;
  assign out_last = ld_r || n == 3'd0 || 3'(m_r) + 3'd1 >= n;

  // results only shown while emitting
  a_ov: assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> st_r == S_EMIT)
    else $error("result valid outside emit");
  a_ld_last: assert property (@(posedge clk) disable iff (!rst_n) (ov_r && ld_r) |-> out_last)
    else $error("load result not last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(m_r) && $stable(ok_r)))
    else $error("stalled result changed");
endmodule
`default_nettype wire

/* tb/sv/markov_model_step_sampler_tb.sv */
// Testbench for markov_model_step_sampler: loads a small sparse model, then runs directed
// and random load/step/reset transactions against a built-in predictor of the sampler.
// Depends on mmss_pkg, mmss_if and the RTL of the block.
`timescale 1ns / 1ps
module markov_model_step_sampler_tb;
  import mmss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] word;
    logic [PROB_W-1:0] prob;
    logic [REW_W-1:0]  rew;
    logic [RM_W-1:0]   rm;
    logic [ACT_W-1:0]  act;
    logic [FRAC_W-1:0] ufrac;
    logic [FRAC_W-1:0] afrac;
  } item_t;

  typedef struct {
    logic              ok;
    logic [COL_W-1:0]  st;
    logic [RM_W-1:0]   rm;
    logic [REW_W-1:0]  rew;
    logic              last;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mmss_in_if  in_if();
  mmss_out_if out_if();

  markov_model_step_sampler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predicted sampler state: tables, present state, reward accumulators and configuration
  int unsigned grp_start[int];
  int unsigned row_start[int];
  int unsigned ent_col[int];
  int unsigned ent_prob[int];
  logic [31:0] st_rew[int];
  logic [31:0] act_rew[int];
  int unsigned cur_state;
  longint      reward_acc[4];
  int unsigned init_state_r, models_used_r, srew_mask_r, arew_mask_r;

  result_t expected_results[$];
  int written_entries[$];
  int model_states[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint sat32(longint a, longint b);
    longint s;
    s = a + b;
    if (s > 64'sd2147483647) return 64'sd2147483647;
    if (s < -64'sd2147483648) return -64'sd2147483648;
    return s;
  endfunction

  function automatic int unsigned reported_models();
    return (models_used_r > 4) ? 4 : models_used_r;
  endfunction

  function automatic void add_state_rewards(int unsigned s);
    for (int m = 0; m < reported_models(); m++)
      if (srew_mask_r[m])
        reward_acc[m] = sat32(reward_acc[m], longint'($signed(st_rew[m * MAX_STATES_D + s])));
  endfunction

  function automatic void push_rewards(logic ok);
    result_t r;
    int n;
    n = reported_models();
    r.ok = ok;
    r.st = cur_state[COL_W-1:0];
    if (n == 0) begin
      r.rm = '0; r.rew = '0; r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int m = 0; m < n; m++) begin
        r.rm = m[RM_W-1:0];
        r.rew = reward_acc[m][31:0];
        r.last = (m == n - 1);
        expected_results.push_back(r);
      end
    end
  endfunction

  // Walk the chosen row of the present state; returns success
  function automatic logic sample_step(item_t it);
    longint g0, g1, act, row, e0, e1, sum;
    g0 = grp_start[cur_state];
    g1 = grp_start[cur_state + 1];
    if (g1 > MAX_ROWS_D) g1 = MAX_ROWS_D;
    if (g1 <= g0) return 0;
    act = it.act;
    if (it.mode == MODE_RSTEP) act = (longint'(it.afrac) * (g1 - g0)) >>> 16;
    if (act >= g1 - g0) return 0;
    row = g0 + act;
    for (int m = 0; m < 4; m++) reward_acc[m] = 0;
    for (int m = 0; m < reported_models(); m++)
      if (arew_mask_r[m])
        reward_acc[m] = sat32(reward_acc[m],
                              longint'($signed(act_rew[m * MAX_ROWS_D + row])));
    e0 = row_start[row];
    e1 = row_start[row + 1];
    if (e1 > MAX_ENTRIES_D) e1 = MAX_ENTRIES_D;
    sum = 0;
    for (longint e = e0; e < e1; e++) begin
      sum += ent_prob[e];
      if (sum > it.ufrac) begin
        if (ent_col[e] >= MAX_STATES_D) return 0;
        cur_state = ent_col[e];
        add_state_rewards(cur_state);
        return 1;
      end
    end
    return 0;
  endfunction

  // Expected results of one accepted transaction
  function automatic void predict_item(item_t it);
    result_t r;
    int a;
    a = it.addr;
    r.ok = 0;
    case (it.mode)
      MODE_STEP, MODE_RSTEP: begin
        push_rewards(sample_step(it));
        return;
      end
      MODE_RESET: begin
        cur_state = (init_state_r >= MAX_STATES_D) ? MAX_STATES_D - 1 : init_state_r;
        for (int m = 0; m < 4; m++) reward_acc[m] = 0;
        add_state_rewards(cur_state);
        push_rewards(1);
        return;
      end
      MODE_GROUP: if (a <= MAX_STATES_D) begin grp_start[a] = it.word; r.ok = 1; end
      MODE_ROW:   if (a <= MAX_ROWS_D) begin row_start[a] = it.word; r.ok = 1; end
      MODE_ENTRY: if (a < MAX_ENTRIES_D) begin
        ent_col[a] = it.col; ent_prob[a] = it.prob; r.ok = 1;
      end
      MODE_SREW: if (a < MAX_STATES_D) begin
        st_rew[it.rm * MAX_STATES_D + a] = it.rew; r.ok = 1;
      end
      default: if (a < MAX_ROWS_D) begin
        act_rew[it.rm * MAX_ROWS_D + a] = it.rew; r.ok = 1;
      end
    endcase
    r.st = cur_state[COL_W-1:0];
    r.rm = '0; r.rew = '0; r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: state %0d rm %0d reward %0d",
                   out_if.current_state, out_if.reward_model_index, out_if.last_reward);
      end else begin
        e = expected_results.pop_front();
        if (out_if.success !== e.ok || out_if.current_state !== e.st ||
            out_if.reward_model_index !== e.rm || out_if.last_reward !== e.rew ||
            out_if.last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok %0d st %0d rm %0d rew %0d last %0d / got %0d %0d %0d %0d %0d",
                     e.ok, e.st, e.rm, $signed(e.rew), e.last, out_if.success,
                     out_if.current_state, out_if.reward_model_index, out_if.last_reward,
                     out_if.last_of_run);
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready = 0;
      hold_left--;
    end else begin
      out_if.ready = rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 0;
      @(negedge clk);
    end
    in_if.valid = 1;
    in_if.mode = it.mode;
    in_if.table_address = it.addr;
    in_if.target_column = it.col;
    in_if.load_word = it.word;
    in_if.entry_probability = it.prob;
    in_if.reward_value = it.rew;
    in_if.reward_model = it.rm;
    in_if.action_index = it.act;
    in_if.random_fraction = it.ufrac;
    in_if.action_fraction = it.afrac;
    do @(posedge clk); while (!in_if.ready);
    predict_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_INIT:  init_state_r = value & 10'h3FF;
      CFG_NUSED: models_used_r = value & 3'h7;
      CFG_SMASK: srew_mask_r = value & 4'hF;
      default:   arew_mask_r = value & 4'hF;
    endcase
  endtask

  task automatic set_config(int unsigned init, int unsigned nused, int unsigned smask,
                            int unsigned amask);
    write_reg(CFG_INIT, init);
    write_reg(CFG_NUSED, nused);
    write_reg(CFG_SMASK, smask);
    write_reg(CFG_AMASK, amask);
  endtask

  function automatic item_t blank_item(mode_t mode);
    item_t it;
    it = '{mode: mode, addr: '0, col: '0, word: '0, prob: '0, rew: '0, rm: '0, act: '0,
           ufrac: '0, afrac: '0};
    return it;
  endfunction

  task automatic send_load(mode_t mode, int addr, int unsigned word, int col,
                           int unsigned prob, logic [31:0] rew, int rm);
    item_t it;
    it = blank_item(mode);
    it.addr = ADDR_W'(addr); it.word = WORD_W'(word); it.col = COL_W'(col);
    it.prob = PROB_W'(prob); it.rew = rew; it.rm = RM_W'(rm);
    send_item(it);
  endtask

  task automatic send_step(mode_t mode, int act, int unsigned ufrac, int unsigned afrac);
    item_t it;
    it = blank_item(mode);
    it.act = ACT_W'(act); it.ufrac = FRAC_W'(ufrac); it.afrac = FRAC_W'(afrac);
    send_item(it);
  endtask

  function automatic int pick_column();
    int k;
    k = $urandom_range(0, 3);
    return (k == 3) ? 1023 : k;
  endfunction

  function automatic logic [31:0] pick_reward();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Model: states 0..2 plus 1023; state 1 has an empty group, row 3 has no entries;
  // state 1023's group is clipped at the row table end and its last row at the entry end.
  task automatic load_model();
    int grp[4] = '{0, 2, 2, 4};
    int ent;
    int cnt;
    for (int s = 0; s <= 3; s++) send_load(MODE_GROUP, s, grp[s], 0, 0, 0, 0);
    send_load(MODE_GROUP, 1023, 4094, 0, 0, 0, 0);
    send_load(MODE_GROUP, 1024, 5000, 0, 0, 0, 0);
    ent = 0;
    for (int r = 0; r <= 4; r++) begin
      send_load(MODE_ROW, r, ent, 0, 0, 0, 0);
      cnt = (r == 0) ? 1 : (r == 3) ? 0 : 2;
      for (int k = 0; k < cnt && r < 4; k++) begin
        written_entries.push_back(ent);
        ent++;
      end
    end
    for (int r = 4094; r <= 4096; r++)
      send_load(MODE_ROW, r, (r == 4096) ? 30000 : 16380 + 2 * (r - 4094), 0, 0, 0, 0);
    for (int e = 16380; e < 16384; e++) written_entries.push_back(e);
    // Entries: mostly random, one certain entry and one zero-probability entry
    foreach (written_entries[i]) begin
      ent = written_entries[i];
      send_load(MODE_ENTRY, ent, 0, pick_column(),
                (ent == 0) ? 0 : (ent == 1) ? 65536 : $urandom_range(0, 40000), 0, 0);
    end
    foreach (model_states[i])
      for (int m = 0; m < 4; m++)
        send_load(MODE_SREW, model_states[i], 0, 0, 0, pick_reward(), m);
    for (int r = 0; r < 4; r++)
      for (int m = 0; m < 4; m++) send_load(MODE_AREW, r, 0, 0, 0, pick_reward(), m);
    for (int r = 4094; r < 4096; r++)
      for (int m = 0; m < 4; m++) send_load(MODE_AREW, r, 0, 0, 0, pick_reward(), m);
    wait_drained();
  endtask

  // Out-of-range addresses for every load kind, and the last in-range entry and action reward
  task automatic test_load_bounds();
    send_load(MODE_GROUP, 1025, 16384, 0, 0, 0, 0);
    send_load(MODE_ROW, 4097, 7, 0, 0, 0, 0);
    send_load(MODE_ROW, 32767, 32767, 0, 0, 0, 0);
    send_load(MODE_ENTRY, 16384, 0, 1023, 65536, 0, 0);
    send_load(MODE_ENTRY, 32767, 0, 512, 131071, 0, 0);
    send_load(MODE_SREW, 1024, 0, 0, 0, 32'h7FFF_FFFF, 3);
    send_load(MODE_AREW, 4096, 0, 0, 0, 32'h8000_0000, 2);
    send_load(MODE_ENTRY, 16383, 0, 1023, 65536, 0, 0);
    send_load(MODE_AREW, 4095, 0, 0, 0, 32'h8000_0000, 3);
    wait_drained();
  endtask

  // Steps: reset, fixed and fraction-picked actions, empty group, out-of-range action
  task automatic test_steps();
    set_config(0, 4, 4'hF, 4'hF);
    send_step(MODE_RESET, 0, 0, 0);
    send_step(MODE_STEP, 0, 0, 0);
    send_step(MODE_STEP, 4095, 65535, 0);
    send_step(MODE_RSTEP, 0, 65535, 65535);
    send_step(MODE_RSTEP, 0, 0, 0);
    wait_drained();
    set_config(1, 0, 0, 0);
    send_step(MODE_RESET, 0, 0, 0);
    send_step(MODE_STEP, 0, 0, 0);
    send_step(MODE_RSTEP, 0, 1000, 30000);
    wait_drained();
    // Largest state: its group runs into the clipped table ends
    set_config(1023, 7, 4'h5, 4'hA);
    send_step(MODE_RESET, 0, 0, 0);
    send_step(MODE_STEP, 1, 65535, 0);
    send_step(MODE_RESET, 0, 0, 0);
    send_step(MODE_STEP, 2, 0, 0);
    send_step(MODE_RSTEP, 0, 0, 65535);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, then sender waits for all
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 8; i++) send_step(MODE_RSTEP, 0, $urandom, $urandom);
    wait_drained();
  endtask

  task automatic run_random(int n, int src_pct, int snk_pct);
    item_t it;
    int k;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n; i++) begin
      it = blank_item(MODE_STEP);
      it.ufrac = FRAC_W'($urandom); it.afrac = FRAC_W'($urandom);
      it.act = ($urandom_range(0, 3) == 0) ? ACT_W'($urandom) : ACT_W'($urandom_range(0, 3));
      k = $urandom_range(0, 99);
      if (k < 35) it.mode = MODE_STEP;
      else if (k < 60) it.mode = MODE_RSTEP;
      else if (k < 68) it.mode = MODE_RESET;
      else if (k < 76) begin
        it.mode = MODE_ENTRY;
        it.addr = ADDR_W'(written_entries[$urandom_range(0, written_entries.size() - 1)]);
        it.col = COL_W'(pick_column());
        it.prob = ($urandom_range(0, 9) == 0) ? PROB_W'(65536)
                                              : PROB_W'($urandom_range(0, 50000));
      end else if (k < 84) begin
        it.mode = ($urandom_range(0, 1) == 0) ? MODE_SREW : MODE_AREW;
        it.rm = RM_W'($urandom);
        it.rew = pick_reward();
        it.addr = (it.mode == MODE_SREW)
                  ? ADDR_W'(model_states[$urandom_range(0, model_states.size() - 1)])
                  : ADDR_W'($urandom_range(0, 3));
      end else begin
        // Noise: loads that are always out of range, every field random
        it.mode = mode_t'($urandom_range(0, 4));
        it.addr = ADDR_W'($urandom_range(MAX_ENTRIES_D, 32767));
        it.col = COL_W'($urandom); it.word = WORD_W'($urandom); it.prob = PROB_W'($urandom);
        it.rew = $urandom; it.rm = RM_W'($urandom);
      end
      send_item(it);
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid = 0;
    in_if.mode = MODE_GROUP;
    in_if.table_address = 0;
    in_if.target_column = 0;
    in_if.load_word = 0;
    in_if.entry_probability = 0;
    in_if.reward_value = 0;
    in_if.reward_model = 0;
    in_if.action_index = 0;
    in_if.random_fraction = 0;
    in_if.action_fraction = 0;
    out_if.ready = 0;
    cur_state = 0;
    foreach (reward_acc[m]) reward_acc[m] = 0;
    init_state_r = 0; models_used_r = 0; srew_mask_r = 0; arew_mask_r = 0;
    for (int s = 0; s < 3; s++) model_states.push_back(s);
    model_states.push_back(1023);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    load_model();
    test_load_bounds();
    test_steps();
    set_config(0, 4, 4'hF, 4'hF);
    test_backpressure();
    run_random(5, 0, 0);
    set_config(1023, 3, 4'h6, 4'h3);
    run_random(5, 72, 0);
    set_config(5, 2, 4'hF, 4'h0);
    run_random(5, 0, 72);
    set_config(0, 0, 4'h0, 4'hF);
    run_random(3, 22, 22);
    set_config(2, 4, 4'h9, 4'hF);
    run_random(3, 22, 22);
    src_idle_pct = 0;
    snk_stall_pct = 0;

    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("covered %0d transactions in, %0d results out, %0d cycles, %0d mismatches",
             items_sent, results_seen, cycles, mismatches);
    $display("loads in and out of range, steps, random steps, resets, five register settings");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
